@@ rtl/trial_division_factorizer_defines.svh @@
// ---------------------------------------------------------------------------
// Trial division factorizer: assertion macros
// Checks are compiled in unless SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_FACTORIZER_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_DEFINES_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset.
`define TDF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tdf assertion failed");

// Check a property on every rising edge, reset included.
`define TDF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tdf assertion failed");

`else

`define TDF_ASSERT(lbl, clk, rst, prop)
`define TDF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/tdf_pkg.sv @@
// ---------------------------------------------------------------------------
// Trial division factorizer: package
// Shared types and fixed constants of the factorizer.
// ---------------------------------------------------------------------------
package tdf_pkg;

  // Width of the factor position field.
  localparam int IDX_W = 5;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TWOS,
    ST_DIV,
    ST_DECIDE
  } tdf_state_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } tdf_div_status_t;

endpackage

@@ rtl/tdf_if.sv @@
// ---------------------------------------------------------------------------
// Trial division factorizer: channel interfaces
// Valid/ready channels for the operand and for the factor results.
// ---------------------------------------------------------------------------
interface tdf_in_if #(parameter int WIDTH = 24) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdf_out_if import tdf_pkg::*; #(parameter int WIDTH = 24) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] factor;
  logic [IDX_W-1:0] factor_index;
  logic             last;

  modport source (output valid, output factor, output factor_index, output last,
                  input ready);
  modport sink   (input valid, input factor, input factor_index, input last,
                  output ready);
endinterface

@@ rtl/tdf_divider.sv @@
// ---------------------------------------------------------------------------
// Trial division factorizer: bit-serial divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "trial_division_factorizer_defines.svh"

module tdf_divider import tdf_pkg::*; #(
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output tdf_div_status_t  status,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] rmd;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rmd, quo[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = ~diff[WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rmd <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CW'(WIDTH - 1);
    end else if (busy) begin
      rmd <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], fits};
      cnt <= cnt - CW'(1);
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;
  assign remainder   = rmd;

  `TDF_ASSERT(a_no_restart, clk, rst, start |-> !busy)
  `TDF_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy) && !busy)

endmodule

@@ rtl/tdf_out_reg.sv @@
// ---------------------------------------------------------------------------
// Trial division factorizer: output register
// Holds one result for the receiver while the sequencer moves on.
// ---------------------------------------------------------------------------
`include "trial_division_factorizer_defines.svh"

module tdf_out_reg import tdf_pkg::*; #(
  parameter int WIDTH = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_factor,
  input  logic [IDX_W-1:0] push_index,
  input  logic             push_last,
  output logic             can_push,
  tdf_out_if.source        out_ch
);

  logic             valid;
  logic [WIDTH-1:0] factor;
  logic [IDX_W-1:0] factor_index;
  logic             last;

  // Free when empty or when the held result leaves this cycle.
  assign can_push = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      factor       <= push_factor;
      factor_index <= push_index;
      last         <= push_last;
    end
  end

  assign out_ch.valid        = valid;
  assign out_ch.factor       = factor;
  assign out_ch.factor_index = factor_index;
  assign out_ch.last         = last;

  `TDF_ASSERT(a_no_overwrite, clk, rst, push |-> can_push)

endmodule

@@ rtl/trial_division_factorizer.sv @@
// ---------------------------------------------------------------------------
// Trial division factorizer
// Emits the prime factors of an unsigned integer in ascending order.
// ---------------------------------------------------------------------------
// Usage:
//   operand : valid/ready request carrying value (WIDTH bits). A request is
//             taken only while the block is idle, one operand at a time.
//   factors : valid/ready results, one per prime factor in ascending order,
//             repeats included, with factor_index counting from zero and
//             last set on the final factor. Inputs 0 and 1 give one result
//             equal to the input.
// Sequence:
//   Factors of two are stripped first. Each trial division is one pass
//   of the bit-serial divider; a divisor that divides is tried again, and
//   the search ends as soon as the quotient drops below the divisor. The
//   next operand is taken the cycle after the last factor is handed to the
//   output register.
// Reset:
//   rst (synchronous) returns the sequencer to idle and empties the output
//   register; no clearing pass is needed.
// Stalls:
//   A result waits in the output register; the sequencer holds only when it
//   has a further result to give and that register is still occupied.
// ---------------------------------------------------------------------------
`include "trial_division_factorizer_defines.svh"

module trial_division_factorizer import tdf_pkg::*; #(
  parameter int WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst,
  tdf_in_if.sink    operand,
  tdf_out_if.source factors
);

  localparam logic [WIDTH-1:0] TWO       = WIDTH'(2);
  localparam logic [WIDTH-1:0] FIRST_ODD = WIDTH'(3);

  tdf_state_t       state;
  tdf_state_t       state_next;
  logic [WIDTH-1:0] rem;          // value still to factor
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] dvs;          // current odd trial divisor
  logic [WIDTH-1:0] dvs_next;
  logic [IDX_W-1:0] cnt;          // factors emitted so far
  logic [IDX_W-1:0] cnt_next;

  logic             push;
  logic [WIDTH-1:0] push_factor;
  logic             push_last;
  logic             can_push;

  logic             div_start;
  tdf_div_status_t  div_status;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rmd;

  // Serial divider: dividend and divisor are latched on start.
  tdf_divider #(.WIDTH(WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem_next),
    .divisor   (dvs_next),
    .status    (div_status),
    .quotient  (div_quo),
    .remainder (div_rmd)
  );

  tdf_out_reg #(.WIDTH(WIDTH)) u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_factor (push_factor),
    .push_index  (cnt),
    .push_last   (push_last),
    .can_push    (can_push),
    .out_ch      (factors)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    dvs <= dvs_next;
  end

  always_comb begin
    state_next    = state;
    rem_next      = rem;
    dvs_next      = dvs;
    cnt_next      = cnt;
    push          = 1'b0;
    push_factor   = rem;
    push_last     = 1'b0;
    div_start     = 1'b0;
    operand.ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        // Take a new request and start with the factors of two.
        if (operand.valid) begin
          rem_next   = operand.value;
          cnt_next   = '0;
          state_next = ST_TWOS;
        end
      end
      ST_TWOS: begin
        if (rem < TWO) begin
          // Zero or one: pass the input through as the only result.
          if (can_push) begin
            push       = 1'b1;
            push_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!rem[0]) begin
          // Strip one factor of two per cycle while the output register can take it.
          if (can_push) begin
            push        = 1'b1;
            push_factor = TWO;
            push_last   = (rem == TWO);
            rem_next    = rem >> 1;
            cnt_next    = cnt + IDX_W'(1);
            if (rem == TWO) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          // Odd and above one: begin trial division at three.
          dvs_next   = FIRST_ODD;
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (div_quo < dvs) begin
          // Divisor squared exceeds the remainder: what is left is prime.
          if (can_push) begin
            push       = 1'b1;
            push_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (div_rmd == '0) begin
          // Divisor divides: emit it and retry the same divisor.
          if (can_push) begin
            push        = 1'b1;
            push_factor = dvs;
            rem_next    = div_quo;
            cnt_next    = cnt + IDX_W'(1);
            div_start   = 1'b1;
            state_next  = ST_DIV;
          end
        end else begin
          // Advance to the next odd divisor.
          dvs_next   = dvs + TWO;
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TDF_ASSERT(a_take_starts_run, clk, rst,
    operand.valid && operand.ready |=> state == ST_TWOS)
  `TDF_ASSERT(a_odd_divisor, clk, rst, state == ST_DECIDE |-> dvs[0] && dvs > TWO)
  `TDF_ASSERT(a_divider_in_div, clk, rst,
    state == ST_DIV |-> div_status.busy || div_status.done)
  `TDF_ASSERT(a_index_bound, clk, rst, push |-> int'(cnt) < WIDTH)

endmodule
